// ===== rtl/gn3f_pkg.sv =====
// Shared types, constants and codes for the 3D fractal gradient noise core.
package gn3f_pkg;

  localparam int TABLE_SIZE_DEF  = 256;
  localparam int MAX_OCTAVES_DEF = 8;

  localparam int OCT_W     = 5;
  localparam int CMD_W     = 2;
  localparam int IDX_W     = 9;
  localparam int PERM_W    = 8;
  localparam int GRAD_W    = 16;
  localparam int GENT_W    = 3 * GRAD_W;
  localparam int COORD_W   = 32;
  localparam int FRAC_W    = 16;
  localparam int SMOOTH_W  = 17;
  localparam int WEIGHT_W  = 17;
  localparam int LAC_W     = 16;
  localparam int DOT_W     = 36;
  localparam int VAL_W     = 38;
  localparam int ACC_W     = 32;
  localparam int NOISE_W   = 16;
  localparam int CFG_W     = 17;
  localparam int CFG_IDX_W = 2;

  localparam logic [COORD_W-1:0]  ONE_Q16   = 32'h0001_0000;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'h1_0000;

  typedef enum logic [CMD_W-1:0] {
    CMD_EVAL = 2'd0,
    CMD_PERM = 2'd1,
    CMD_GRAD = 2'd2
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OCTAVES     = 2'd0,
    CFG_LACUNARITY  = 2'd1,
    CFG_PERSISTENCE = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_COORD,
    ST_START,
    ST_WAIT,
    ST_WEIGHT,
    ST_FIN
  } top_state_t;

  typedef enum logic [3:0] {
    U_IDLE,
    U_SM_A,
    U_SM_B,
    U_H0,
    U_H1,
    U_H2,
    U_H3,
    U_D0,
    U_D1,
    U_D2,
    U_BL_A,
    U_BL_B
  } oct_state_t;

  typedef struct packed {
    logic               start;
    logic [COORD_W-1:0] sc_x;
    logic [COORD_W-1:0] sc_y;
    logic [COORD_W-1:0] sc_z;
  } oct_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [VAL_W-1:0] value;
  } oct_sts_t;

endpackage

// ===== rtl/gn3f_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module gn3f_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/gn3f_octave.sv =====
// One octave of gradient noise: smoothstep, corner hashing, dot products, trilinear blend.
module gn3f_octave #(
  parameter int TABLE_SIZE = gn3f_pkg::TABLE_SIZE_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  gn3f_pkg::oct_req_t                  req,
  output gn3f_pkg::oct_sts_t                  sts,
  output logic [$clog2(TABLE_SIZE):0]         perm_raddr,
  input  logic [gn3f_pkg::PERM_W-1:0]         perm_rdata,
  output logic [$clog2(TABLE_SIZE)-1:0]       grad_raddr,
  input  logic [gn3f_pkg::GENT_W-1:0]         grad_rdata
);

  localparam int TIW = $clog2(TABLE_SIZE);
  localparam int PIW = TIW + 1;
  localparam int FW  = gn3f_pkg::FRAC_W;
  localparam int SW  = gn3f_pkg::SMOOTH_W;
  localparam int VW  = gn3f_pkg::VAL_W;
  localparam int DW  = gn3f_pkg::DOT_W;
  localparam int GW  = gn3f_pkg::GRAD_W;

  gn3f_pkg::oct_state_t state_r, state_nxt;

  logic [2:0]           c_r;
  logic [1:0]           ax_r;
  logic [2:0]           k_r;
  logic [FW-1:0]        t2_r;
  logic [SW-1:0]        s_r [3];
  logic signed [DW-1:0] dsum_r;
  logic [TIW-1:0]       gidx_r;
  logic signed [VW-1:0] q_r [8];
  logic signed [VW+2:0] bsh_r;

  logic [FW-1:0]        fx, fy, fz, t_cur;
  logic [TIW-1:0]       cx, cy, cz;
  logic [FW+1:0]        poly;
  logic signed [FW+1:0] dx, dy, dz;
  logic signed [18:0]   ma, mb;
  logic signed [37:0]   mp;
  logic signed [DW-1:0] dot_sum;
  logic [SW-1:0]        s_sel;
  logic signed [VW:0]   diff;
  logic signed [VW+18:0] bprod;
  logic signed [VW+2:0] bsum;
  logic signed [VW-1:0] blend_res;

  assign fx = req.sc_x[FW-1:0];
  assign fy = req.sc_y[FW-1:0];
  assign fz = req.sc_z[FW-1:0];
  assign cx = req.sc_x[FW +: TIW] + TIW'(c_r[0]);
  assign cy = req.sc_y[FW +: TIW] + TIW'(c_r[1]);
  assign cz = req.sc_z[FW +: TIW] + TIW'(c_r[2]);

  assign dx = $signed({2'b00, fx}) - (c_r[0] ? 18'sd65536 : 18'sd0);
  assign dy = $signed({2'b00, fy}) - (c_r[1] ? 18'sd65536 : 18'sd0);
  assign dz = $signed({2'b00, fz}) - (c_r[2] ? 18'sd65536 : 18'sd0);

  always_comb begin
    case (ax_r)
      2'd0:    t_cur = fx;
      2'd1:    t_cur = fy;
      default: t_cur = fz;
    endcase
  end

  assign poly = 18'd196608 - {1'b0, t_cur, 1'b0};

  always_comb begin
    ma = '0;
    mb = '0;
    case (state_r)
      gn3f_pkg::U_SM_A: begin
        ma = $signed({3'b000, t_cur});
        mb = $signed({3'b000, t_cur});
      end
      gn3f_pkg::U_SM_B: begin
        ma = $signed({3'b000, t2_r});
        mb = $signed({1'b0, poly});
      end
      gn3f_pkg::U_D0: begin
        ma = $signed({{3{grad_rdata[3*GW-1]}}, grad_rdata[3*GW-1:2*GW]});
        mb = $signed({dx[FW+1], dx});
      end
      gn3f_pkg::U_D1: begin
        ma = $signed({{3{grad_rdata[2*GW-1]}}, grad_rdata[2*GW-1:GW]});
        mb = $signed({dy[FW+1], dy});
      end
      gn3f_pkg::U_D2: begin
        ma = $signed({{3{grad_rdata[GW-1]}}, grad_rdata[GW-1:0]});
        mb = $signed({dz[FW+1], dz});
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign mp      = ma * mb;
  assign dot_sum = dsum_r + $signed(mp[DW-1:0]);

  always_comb begin
    case (state_r)
      gn3f_pkg::U_H0: perm_raddr = PIW'(cx);
      gn3f_pkg::U_H1: perm_raddr = PIW'(perm_rdata) + PIW'(cy);
      gn3f_pkg::U_H2: perm_raddr = PIW'(perm_rdata) + PIW'(cz);
      default:        perm_raddr = '0;
    endcase
  end

  assign grad_raddr = (state_r == gn3f_pkg::U_H3) ? TIW'(perm_rdata) : gidx_r;

  assign s_sel     = (k_r < 3'd4) ? s_r[0] : ((k_r < 3'd6) ? s_r[1] : s_r[2]);
  assign diff      = $signed({q_r[1][VW-1], q_r[1]}) - $signed({q_r[0][VW-1], q_r[0]});
  assign bprod     = diff * $signed({1'b0, s_sel});
  assign bsum      = $signed({{3{q_r[0][VW-1]}}, q_r[0]}) + bsh_r;
  assign blend_res = bsum[VW-1:0];

  assign sts.done  = (state_r == gn3f_pkg::U_BL_B) && (k_r == 3'd6);
  assign sts.value = blend_res;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gn3f_pkg::U_IDLE: if (req.start) state_nxt = gn3f_pkg::U_SM_A;
      gn3f_pkg::U_SM_A: state_nxt = gn3f_pkg::U_SM_B;
      gn3f_pkg::U_SM_B: state_nxt = (ax_r == 2'd2) ? gn3f_pkg::U_H0 : gn3f_pkg::U_SM_A;
      gn3f_pkg::U_H0:   state_nxt = gn3f_pkg::U_H1;
      gn3f_pkg::U_H1:   state_nxt = gn3f_pkg::U_H2;
      gn3f_pkg::U_H2:   state_nxt = gn3f_pkg::U_H3;
      gn3f_pkg::U_H3:   state_nxt = gn3f_pkg::U_D0;
      gn3f_pkg::U_D0:   state_nxt = gn3f_pkg::U_D1;
      gn3f_pkg::U_D1:   state_nxt = gn3f_pkg::U_D2;
      gn3f_pkg::U_D2:   state_nxt = (c_r == 3'd7) ? gn3f_pkg::U_BL_A : gn3f_pkg::U_H0;
      gn3f_pkg::U_BL_A: state_nxt = gn3f_pkg::U_BL_B;
      gn3f_pkg::U_BL_B: state_nxt = (k_r == 3'd6) ? gn3f_pkg::U_IDLE : gn3f_pkg::U_BL_A;
      default:          state_nxt = gn3f_pkg::U_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gn3f_pkg::U_IDLE;
      c_r     <= '0;
      ax_r    <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        gn3f_pkg::U_IDLE: begin
          ax_r <= '0;
          c_r  <= '0;
          k_r  <= '0;
        end
        gn3f_pkg::U_SM_B: if (ax_r != 2'd2) ax_r <= ax_r + 2'd1;
        gn3f_pkg::U_D2:   c_r <= c_r + 3'd1;
        gn3f_pkg::U_BL_B: k_r <= k_r + 3'd1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      gn3f_pkg::U_SM_A: t2_r <= mp[31:16];
      gn3f_pkg::U_SM_B: s_r[ax_r] <= mp[32:16];
      gn3f_pkg::U_H3:   gidx_r <= TIW'(perm_rdata);
      gn3f_pkg::U_D0:   dsum_r <= $signed(mp[DW-1:0]);
      gn3f_pkg::U_D1:   dsum_r <= dot_sum;
      gn3f_pkg::U_D2:   q_r[c_r] <= $signed({{(VW-DW){dot_sum[DW-1]}}, dot_sum});
      gn3f_pkg::U_BL_A: bsh_r <= bprod[VW+18:16];
      gn3f_pkg::U_BL_B: begin
        for (int j = 0; j < 6; j++) begin
          q_r[j] <= (3'(j) == 3'd6 - k_r) ? blend_res : q_r[j+2];
        end
        if (k_r == 3'd0) q_r[6] <= blend_res;
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/gradient_noise_3d_fractal_core.sv =====
// Top level of the 3D fractal gradient noise core: commands, octave loop, result register.
// An evaluation runs N octaves, with N the configured octave count capped at MAX_OCTAVES.
// Each octave in the octave unit does 24 serial permutation reads and
// 8 gradient reads on single-read-port RAMs, with a shared multiplier, then 7 blends.
// One item is in flight at a time; the result register frees the input side.
// Synchronous active-low reset clears control and config; tables stay undefined.
module gradient_noise_3d_fractal_core #(
  parameter int TABLE_SIZE  = gn3f_pkg::TABLE_SIZE_DEF,
  parameter int MAX_OCTAVES = gn3f_pkg::MAX_OCTAVES_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [gn3f_pkg::CMD_W-1:0]            in_cmd,
  input  logic [gn3f_pkg::IDX_W-1:0]            in_table_index,
  input  logic [gn3f_pkg::PERM_W-1:0]           in_table_value,
  input  logic signed [gn3f_pkg::GRAD_W-1:0]    in_grad_x,
  input  logic signed [gn3f_pkg::GRAD_W-1:0]    in_grad_y,
  input  logic signed [gn3f_pkg::GRAD_W-1:0]    in_grad_z,
  input  logic signed [gn3f_pkg::COORD_W-1:0]   in_coord_x,
  input  logic signed [gn3f_pkg::COORD_W-1:0]   in_coord_y,
  input  logic signed [gn3f_pkg::COORD_W-1:0]   in_coord_z,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [gn3f_pkg::NOISE_W-1:0]   out_noise_value,
  output logic                                  out_saturated,
  input  logic                                  cfg_we,
  input  logic [gn3f_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [gn3f_pkg::CFG_W-1:0]            cfg_wdata
);

  localparam int TIW = $clog2(TABLE_SIZE);
  localparam int PIW = TIW + 1;
  localparam int OW  = gn3f_pkg::OCT_W;
  localparam int CW  = gn3f_pkg::COORD_W;
  localparam int WW  = gn3f_pkg::WEIGHT_W;
  localparam int LW  = gn3f_pkg::LAC_W;
  localparam int VW  = gn3f_pkg::VAL_W;
  localparam int AW  = gn3f_pkg::ACC_W;

  gn3f_pkg::top_state_t state_r, state_nxt;

  logic [3:0]           oct_cnt_r;
  logic [LW-1:0]        lac_r;
  logic [WW-1:0]        pers_r;
  logic signed [CW-1:0] coord_r [3];
  logic [CW-1:0]        scale_r;
  logic [WW-1:0]        weight_r;
  logic signed [AW-1:0] acc_r;
  logic [OW-1:0]        left_r;
  logic [1:0]           axis_r;
  logic [CW-1:0]        sc_r [3];
  logic signed [VW-1:0] g_r;
  logic                 out_valid_r;
  logic signed [gn3f_pkg::NOISE_W-1:0] out_noise_r;
  logic                 out_sat_r;

  logic                 in_fire;
  logic                 out_free;
  logic [OW-1:0]        n_eff;
  logic [WW-1:0]        pers_eff;
  logic [CW+LW-1:0]     sprod;
  logic [2*WW-1:0]      wprod;
  logic signed [2*CW:0] cprod;
  logic signed [VW+WW:0] gprod;
  logic signed [AW-1:0] acc_add;

  logic                 perm_we, grad_we;
  logic [PIW-1:0]       perm_raddr;
  logic [gn3f_pkg::PERM_W-1:0] perm_rdata;
  logic [TIW-1:0]       grad_raddr;
  logic [gn3f_pkg::GENT_W-1:0] grad_rdata;

  gn3f_pkg::oct_req_t   oct_req;
  gn3f_pkg::oct_sts_t   oct_sts;

  assign in_ready  = (state_r == gn3f_pkg::ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;

  assign n_eff    = (OW'(oct_cnt_r) > OW'(MAX_OCTAVES)) ? OW'(MAX_OCTAVES) : OW'(oct_cnt_r);
  assign pers_eff = (pers_r > gn3f_pkg::WEIGHT_ONE) ? gn3f_pkg::WEIGHT_ONE : pers_r;

  assign sprod   = scale_r * lac_r;
  assign wprod   = weight_r * pers_eff;
  assign cprod   = coord_r[axis_r] * $signed({1'b0, scale_r});
  assign gprod   = g_r * $signed({1'b0, weight_r});
  assign acc_add = acc_r + $signed({{(AW-(VW+WW-31)){gprod[VW+WW]}}, gprod[VW+WW:32]});

  assign perm_we = in_fire && (in_cmd == gn3f_pkg::CMD_PERM) &&
                   (32'(in_table_index) < 32'(2 * TABLE_SIZE));
  assign grad_we = in_fire && (in_cmd == gn3f_pkg::CMD_GRAD) &&
                   (32'(in_table_index) < 32'(TABLE_SIZE));

  gn3f_ram #(
    .WIDTH (gn3f_pkg::PERM_W),
    .DEPTH (2 * TABLE_SIZE)
  ) u_perm_ram (
    .clk   (clk),
    .we    (perm_we),
    .waddr (PIW'(in_table_index)),
    .wdata (in_table_value),
    .raddr (perm_raddr),
    .rdata (perm_rdata)
  );

  gn3f_ram #(
    .WIDTH (gn3f_pkg::GENT_W),
    .DEPTH (TABLE_SIZE)
  ) u_grad_ram (
    .clk   (clk),
    .we    (grad_we),
    .waddr (TIW'(in_table_index)),
    .wdata ({in_grad_x, in_grad_y, in_grad_z}),
    .raddr (grad_raddr),
    .rdata (grad_rdata)
  );

  assign oct_req.start = (state_r == gn3f_pkg::ST_START);
  assign oct_req.sc_x  = sc_r[0];
  assign oct_req.sc_y  = sc_r[1];
  assign oct_req.sc_z  = sc_r[2];

  gn3f_octave #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_octave (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (oct_req),
    .sts        (oct_sts),
    .perm_raddr (perm_raddr),
    .perm_rdata (perm_rdata),
    .grad_raddr (grad_raddr),
    .grad_rdata (grad_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gn3f_pkg::ST_IDLE: begin
        if (in_fire && (in_cmd == gn3f_pkg::CMD_EVAL)) begin
          state_nxt = (n_eff == '0) ? gn3f_pkg::ST_FIN : gn3f_pkg::ST_SCALE;
        end
      end
      gn3f_pkg::ST_SCALE:  state_nxt = gn3f_pkg::ST_COORD;
      gn3f_pkg::ST_COORD:  if (axis_r == 2'd2) state_nxt = gn3f_pkg::ST_START;
      gn3f_pkg::ST_START:  state_nxt = gn3f_pkg::ST_WAIT;
      gn3f_pkg::ST_WAIT:   if (oct_sts.done) state_nxt = gn3f_pkg::ST_WEIGHT;
      gn3f_pkg::ST_WEIGHT: begin
        state_nxt = (left_r == OW'(1)) ? gn3f_pkg::ST_FIN : gn3f_pkg::ST_SCALE;
      end
      gn3f_pkg::ST_FIN:    if (out_free) state_nxt = gn3f_pkg::ST_IDLE;
      default:             state_nxt = gn3f_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gn3f_pkg::ST_IDLE;
      oct_cnt_r   <= 4'd1;
      lac_r       <= LW'(256);
      pers_r      <= gn3f_pkg::WEIGHT_ONE;
      out_valid_r <= 1'b0;
      axis_r      <= '0;
      left_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          gn3f_pkg::CFG_OCTAVES:     oct_cnt_r <= cfg_wdata[3:0];
          gn3f_pkg::CFG_LACUNARITY:  lac_r     <= cfg_wdata[LW-1:0];
          gn3f_pkg::CFG_PERSISTENCE: pers_r    <= cfg_wdata;
          default: ;
        endcase
      end
      if ((state_r == gn3f_pkg::ST_FIN) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        gn3f_pkg::ST_IDLE:   left_r <= n_eff;
        gn3f_pkg::ST_SCALE:  axis_r <= '0;
        gn3f_pkg::ST_COORD:  axis_r <= axis_r + 2'd1;
        gn3f_pkg::ST_WEIGHT: left_r <= left_r - OW'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      gn3f_pkg::ST_IDLE: begin
        coord_r[0] <= in_coord_x;
        coord_r[1] <= in_coord_y;
        coord_r[2] <= in_coord_z;
        scale_r    <= gn3f_pkg::ONE_Q16;
        weight_r   <= gn3f_pkg::WEIGHT_ONE;
        acc_r      <= '0;
      end
      gn3f_pkg::ST_SCALE: begin
        scale_r  <= (|sprod[CW+LW-1:CW+8]) ? '1 : sprod[CW+7:8];
        weight_r <= wprod[WW+15:16];
      end
      gn3f_pkg::ST_COORD:  sc_r[axis_r] <= cprod[CW+15:16];
      gn3f_pkg::ST_WAIT:   if (oct_sts.done) g_r <= oct_sts.value;
      gn3f_pkg::ST_WEIGHT: acc_r <= acc_add;
      gn3f_pkg::ST_FIN: begin
        if (out_free) begin
          if (acc_r > 32'sd32767) begin
            out_noise_r <= 16'sh7fff;
            out_sat_r   <= 1'b1;
          end else if (acc_r < -32'sd32768) begin
            out_noise_r <= -16'sh8000;
            out_sat_r   <= 1'b1;
          end else begin
            out_noise_r <= acc_r[gn3f_pkg::NOISE_W-1:0];
            out_sat_r   <= 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_noise_value = out_noise_r;
  assign out_saturated   = out_sat_r;

  a_table_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (perm_we || grad_we) |-> (state_r == gn3f_pkg::ST_IDLE))
    else $error("table write outside idle");

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    oct_sts.done |-> (state_r == gn3f_pkg::ST_WAIT))
    else $error("octave done while not waiting");

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == gn3f_pkg::ST_FIN))
    else $error("result without finish");

  a_sat_clip: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_sat_r) |->
      (out_noise_r == 16'sh7fff || out_noise_r == -16'sh8000))
    else $error("saturation flag without clipped value");

endmodule
